// ===== src/steq_pkg.sv =====
`default_nettype none

package steq_pkg;

    localparam int DEPTH   = 16;
    localparam int ID_BITS = 16;
    localparam int WAKE_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ENTRY_W = ID_BITS + WAKE_W;

    typedef enum logic [2:0] {
        OP_SCHEDULE   = 3'd0,
        OP_CANCEL     = 3'd1,
        OP_POP_DUE    = 3'd2,
        OP_RESCHEDULE = 3'd3,
        OP_FINISH     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOPOP  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CHECK,
        S_INS_EV,
        S_SCAN_CHECK,
        S_SCAN_EV,
        S_SHIFT_CHECK,
        S_SHIFT_EV,
        S_POP_EV,
        S_FIN_CHECK,
        S_FIN_EV
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_COUNT
    } t_idx_op;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_PREV,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW,
        WR_MOVE,
        WR_SUB
    } t_wr_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    ins_init;
        logic    ins_popped;
        logic    fin_commit;
        logic    pop_commit;
        logic    cap_hit;
        t_idx_op idx_op;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        t_cnt_op cnt_op;
        logic    emit;
        t_status status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
        logic popped_valid;
        logic idx_zero;
        logic idx_end;
        logic shift_last;
        logic later;
        logic id_match;
        logic due;
    } t_stat;

endpackage

`default_nettype wire

// ===== src/steq_ram.sv =====
`default_nettype none

module steq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/steq_dp.sv =====
`default_nettype none

module steq_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [2:0]                    i_op,
    input  wire logic [steq_pkg::ID_BITS-1:0]  i_routine_id,
    input  wire logic [steq_pkg::WAKE_W-1:0]   i_amount,
    input  wire steq_pkg::t_cmd                i_cmd,
    output steq_pkg::t_stat                    o_stat,
    output logic                               o_valid,
    output logic [1:0]                         o_status,
    output logic [steq_pkg::ID_BITS-1:0]       o_entry_id,
    output logic [steq_pkg::WAKE_W-1:0]        o_due_time,
    output logic [steq_pkg::CNT_W-1:0]         o_pending_count
);

    // control state
    logic [steq_pkg::CNT_W-1:0]   r_count, n_count;
    logic [steq_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic [steq_pkg::WAKE_W-1:0]  r_proc_time;
    logic [steq_pkg::ID_BITS-1:0] r_last_id;
    logic                         r_popped_valid;
    logic [steq_pkg::ID_BITS-1:0] r_pop_id;
    logic [steq_pkg::WAKE_W-1:0]  r_pop_wake;
    logic                         r_valid;

    // request and work registers
    steq_pkg::t_op                r_op;
    logic [steq_pkg::ID_BITS-1:0] r_rid;
    logic [steq_pkg::WAKE_W-1:0]  r_amount;
    logic [steq_pkg::WAKE_W-1:0]  r_new_wake, n_new_wake;
    logic [steq_pkg::ID_BITS-1:0] r_new_id, n_new_id;
    logic [steq_pkg::ID_BITS-1:0] r_res_id;
    logic [steq_pkg::WAKE_W-1:0]  r_res_wake;
    logic [1:0]                   r_status;
    logic [steq_pkg::CNT_W-1:0]   r_pend;

    logic [steq_pkg::WAKE_W-1:0]  base_wake;
    logic [steq_pkg::WAKE_W:0]    wake_sum;
    logic [steq_pkg::CNT_W-1:0]   idx_next;
    logic [steq_pkg::CNT_W-1:0]   idx_prev;
    logic [steq_pkg::CNT_W-1:0]   rd_idx;
    logic [steq_pkg::ENTRY_W-1:0] rd_data;
    logic [steq_pkg::ID_BITS-1:0] rd_id;
    logic [steq_pkg::WAKE_W-1:0]  rd_wake;
    logic [steq_pkg::WAKE_W-1:0]  sub_wake;
    logic                         wr_en;
    logic [steq_pkg::ENTRY_W-1:0] wr_data;

    assign idx_next = r_idx + 1'b1;
    assign idx_prev = r_idx - 1'b1;
    assign rd_id    = rd_data[steq_pkg::ENTRY_W-1:steq_pkg::WAKE_W];
    assign rd_wake  = rd_data[steq_pkg::WAKE_W-1:0];

    // saturating add for the new wake time
    assign base_wake  = i_cmd.ins_popped ? r_pop_wake : r_proc_time;
    assign wake_sum   = {1'b0, base_wake} + {1'b0, r_amount};
    assign n_new_wake = wake_sum[steq_pkg::WAKE_W] ? '1 : wake_sum[steq_pkg::WAKE_W-1:0];
    assign n_new_id   = i_cmd.ins_popped ? r_pop_id : r_last_id + 1'b1;

    assign sub_wake = (rd_wake > r_amount) ? rd_wake - r_amount : '0;

    always_comb begin
        unique case (i_cmd.rd_sel)
            steq_pkg::RD_PREV: rd_idx = idx_prev;
            steq_pkg::RD_NEXT: rd_idx = idx_next;
            default:           rd_idx = r_idx;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        unique case (i_cmd.wr_sel)
            steq_pkg::WR_NEW:  wr_data = {r_new_id, r_new_wake};
            steq_pkg::WR_MOVE: wr_data = rd_data;
            steq_pkg::WR_SUB:  wr_data = {rd_id, sub_wake};
            default: begin
                wr_en   = 1'b0;
                wr_data = rd_data;
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.idx_op)
            steq_pkg::IDX_ZERO:  n_idx = '0;
            steq_pkg::IDX_INC:   n_idx = idx_next;
            steq_pkg::IDX_DEC:   n_idx = idx_prev;
            steq_pkg::IDX_COUNT: n_idx = r_count;
            default:             n_idx = r_idx;
        endcase
    end

    always_comb begin
        unique case (i_cmd.cnt_op)
            steq_pkg::CNT_INC: n_count = r_count + 1'b1;
            steq_pkg::CNT_DEC: n_count = r_count - 1'b1;
            default:           n_count = r_count;
        endcase
    end

    steq_ram #(
        .WIDTH (steq_pkg::ENTRY_W),
        .DEPTH (steq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_idx[steq_pkg::ADDR_W-1:0]),
        .i_wdata (wr_data),
        .i_raddr (rd_idx[steq_pkg::ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_idx          <= '0;
            r_proc_time    <= '0;
            r_last_id      <= '0;
            r_popped_valid <= 1'b0;
            r_pop_id       <= '0;
            r_pop_wake     <= '0;
            r_valid        <= 1'b0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            r_valid <= i_cmd.emit;
            if (i_cmd.ins_init) begin
                if (i_cmd.ins_popped) begin
                    r_popped_valid <= 1'b0;
                end else begin
                    r_last_id <= n_new_id;
                end
            end
            if (i_cmd.pop_commit) begin
                r_proc_time    <= rd_wake;
                r_pop_id       <= rd_id;
                r_pop_wake     <= rd_wake;
                r_popped_valid <= 1'b1;
            end
            if (i_cmd.fin_commit) begin
                r_proc_time    <= '0;
                r_popped_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= steq_pkg::t_op'(i_op);
            r_rid      <= i_routine_id;
            r_amount   <= i_amount;
            r_res_id   <= '0;
            r_res_wake <= '0;
        end
        if (i_cmd.ins_init) begin
            r_new_wake <= n_new_wake;
            r_new_id   <= n_new_id;
            r_res_wake <= n_new_wake;
            r_res_id   <= n_new_id;
        end
        if (i_cmd.cap_hit) begin
            r_res_id   <= rd_id;
            r_res_wake <= rd_wake;
        end
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
            r_pend   <= n_count;
        end
    end

    always_comb begin
        o_stat.op           = r_op;
        o_stat.full         = (r_count == steq_pkg::CNT_W'(steq_pkg::DEPTH));
        o_stat.empty        = (r_count == '0);
        o_stat.popped_valid = r_popped_valid;
        o_stat.idx_zero     = (r_idx == '0);
        o_stat.idx_end      = (r_idx == r_count);
        o_stat.shift_last   = (idx_next >= r_count);
        o_stat.later        = (rd_wake > r_new_wake);
        o_stat.id_match     = (rd_id == r_rid);
        o_stat.due          = (rd_wake <= r_amount);
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_entry_id      = r_res_id;
    assign o_due_time      = r_res_wake;
    assign o_pending_count = r_pend;

endmodule

`default_nettype wire

// ===== src/steq_ctrl.sv =====
`default_nettype none

module steq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire steq_pkg::t_stat i_stat,
    output steq_pkg::t_cmd       o_cmd,
    output logic                 o_busy
);

    steq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= steq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            steq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = steq_pkg::S_DISPATCH;
                end
            end
            steq_pkg::S_DISPATCH: begin
                unique case (i_stat.op)
                    steq_pkg::OP_SCHEDULE:
                        n_state = i_stat.full ? steq_pkg::S_IDLE : steq_pkg::S_INS_CHECK;
                    steq_pkg::OP_RESCHEDULE:
                        n_state = (!i_stat.popped_valid || i_stat.full) ?
                                  steq_pkg::S_IDLE : steq_pkg::S_INS_CHECK;
                    steq_pkg::OP_CANCEL:
                        n_state = steq_pkg::S_SCAN_CHECK;
                    steq_pkg::OP_POP_DUE:
                        n_state = i_stat.empty ? steq_pkg::S_IDLE : steq_pkg::S_POP_EV;
                    steq_pkg::OP_FINISH:
                        n_state = steq_pkg::S_FIN_CHECK;
                    default:
                        n_state = steq_pkg::S_IDLE;
                endcase
            end
            steq_pkg::S_INS_CHECK:
                n_state = i_stat.idx_zero ? steq_pkg::S_IDLE : steq_pkg::S_INS_EV;
            steq_pkg::S_INS_EV:
                n_state = i_stat.later ? steq_pkg::S_INS_CHECK : steq_pkg::S_IDLE;
            steq_pkg::S_SCAN_CHECK:
                n_state = i_stat.idx_end ? steq_pkg::S_IDLE : steq_pkg::S_SCAN_EV;
            steq_pkg::S_SCAN_EV:
                n_state = i_stat.id_match ? steq_pkg::S_SHIFT_CHECK : steq_pkg::S_SCAN_CHECK;
            steq_pkg::S_SHIFT_CHECK:
                n_state = i_stat.shift_last ? steq_pkg::S_IDLE : steq_pkg::S_SHIFT_EV;
            steq_pkg::S_SHIFT_EV:
                n_state = steq_pkg::S_SHIFT_CHECK;
            steq_pkg::S_POP_EV:
                n_state = i_stat.due ? steq_pkg::S_SHIFT_CHECK : steq_pkg::S_IDLE;
            steq_pkg::S_FIN_CHECK:
                n_state = i_stat.idx_end ? steq_pkg::S_IDLE : steq_pkg::S_FIN_EV;
            steq_pkg::S_FIN_EV:
                n_state = steq_pkg::S_FIN_CHECK;
            default:
                n_state = steq_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.idx_op = steq_pkg::IDX_HOLD;
        o_cmd.rd_sel = steq_pkg::RD_IDX;
        o_cmd.wr_sel = steq_pkg::WR_NONE;
        o_cmd.cnt_op = steq_pkg::CNT_HOLD;
        o_cmd.status = steq_pkg::ST_OK;
        o_busy       = 1'b1;
        unique case (r_state)
            steq_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.idx_op = steq_pkg::IDX_ZERO;
                end
            end
            steq_pkg::S_DISPATCH: begin
                unique case (i_stat.op)
                    steq_pkg::OP_SCHEDULE: begin
                        if (i_stat.full) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = steq_pkg::ST_FULL;
                        end else begin
                            o_cmd.ins_init = 1'b1;
                            o_cmd.idx_op   = steq_pkg::IDX_COUNT;
                        end
                    end
                    steq_pkg::OP_RESCHEDULE: begin
                        if (!i_stat.popped_valid) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = steq_pkg::ST_NOPOP;
                        end else if (i_stat.full) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = steq_pkg::ST_FULL;
                        end else begin
                            o_cmd.ins_init   = 1'b1;
                            o_cmd.ins_popped = 1'b1;
                            o_cmd.idx_op     = steq_pkg::IDX_COUNT;
                        end
                    end
                    steq_pkg::OP_CANCEL: begin
                    end
                    steq_pkg::OP_POP_DUE: begin
                        // head entry is read here, evaluated next cycle
                        if (i_stat.empty) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = steq_pkg::ST_ABSENT;
                        end
                    end
                    steq_pkg::OP_FINISH: begin
                        o_cmd.fin_commit = 1'b1;
                    end
                    default: begin
                        o_cmd.emit = 1'b1;
                    end
                endcase
            end
            steq_pkg::S_INS_CHECK: begin
                if (i_stat.idx_zero) begin
                    o_cmd.wr_sel = steq_pkg::WR_NEW;
                    o_cmd.cnt_op = steq_pkg::CNT_INC;
                    o_cmd.emit   = 1'b1;
                end else begin
                    o_cmd.rd_sel = steq_pkg::RD_PREV;
                end
            end
            steq_pkg::S_INS_EV: begin
                // walk down from the tail, moving later entries up by one
                if (i_stat.later) begin
                    o_cmd.wr_sel = steq_pkg::WR_MOVE;
                    o_cmd.idx_op = steq_pkg::IDX_DEC;
                end else begin
                    o_cmd.wr_sel = steq_pkg::WR_NEW;
                    o_cmd.cnt_op = steq_pkg::CNT_INC;
                    o_cmd.emit   = 1'b1;
                end
            end
            steq_pkg::S_SCAN_CHECK: begin
                if (i_stat.idx_end) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = steq_pkg::ST_ABSENT;
                end
            end
            steq_pkg::S_SCAN_EV: begin
                if (i_stat.id_match) begin
                    o_cmd.cap_hit = 1'b1;
                end else begin
                    o_cmd.idx_op = steq_pkg::IDX_INC;
                end
            end
            steq_pkg::S_SHIFT_CHECK: begin
                if (i_stat.shift_last) begin
                    o_cmd.cnt_op = steq_pkg::CNT_DEC;
                    o_cmd.emit   = 1'b1;
                end else begin
                    o_cmd.rd_sel = steq_pkg::RD_NEXT;
                end
            end
            steq_pkg::S_SHIFT_EV: begin
                o_cmd.wr_sel = steq_pkg::WR_MOVE;
                o_cmd.idx_op = steq_pkg::IDX_INC;
            end
            steq_pkg::S_POP_EV: begin
                if (i_stat.due) begin
                    o_cmd.cap_hit    = 1'b1;
                    o_cmd.pop_commit = 1'b1;
                end else begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = steq_pkg::ST_ABSENT;
                end
            end
            steq_pkg::S_FIN_CHECK: begin
                if (i_stat.idx_end) begin
                    o_cmd.emit = 1'b1;
                end
            end
            steq_pkg::S_FIN_EV: begin
                o_cmd.wr_sel = steq_pkg::WR_SUB;
                o_cmd.idx_op = steq_pkg::IDX_INC;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/sorted_timer_event_queue.sv =====
// Sorted timer event queue: up to DEPTH entries (wake time, id) kept in
// wake-time order in a single-port-read RAM.
// Request channel: drive i_op, i_routine_id and i_amount with start high;
// the request is taken at a clock edge where busy is low. busy stays high
// until the request is done.
// Result channel: o_valid is high for exactly one cycle with o_status,
// o_entry_id, o_due_time and o_pending_count. The receiver cannot stall;
// results must be taken in that cycle.
// Ops that fail at once emit their result from the dispatch state; an
// insert, cancel, pop or finish walks the table. Each visited entry takes
// a check state that issues the RAM read and an evaluate state that uses
// the registered data and, where needed, writes it back. busy drops in the
// cycle the result shows, so a new request can start then; one request is
// in flight at a time.
// Reset (i_rst_n low, synchronous) empties the table, clears processed
// time, the id counter and the popped entry. No clearing pass is needed:
// RAM slots past the entry count are never read.
`default_nettype none

module sorted_timer_event_queue (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [2:0]                   i_op,
    input  wire logic [steq_pkg::ID_BITS-1:0] i_routine_id,
    input  wire logic [steq_pkg::WAKE_W-1:0]  i_amount,
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic [steq_pkg::ID_BITS-1:0]      o_entry_id,
    output logic [steq_pkg::WAKE_W-1:0]       o_due_time,
    output logic [steq_pkg::CNT_W-1:0]        o_pending_count
);

    steq_pkg::t_cmd  cmd;
    steq_pkg::t_stat stat;

    steq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    steq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (i_op),
        .i_routine_id    (i_routine_id),
        .i_amount        (i_amount),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_entry_id      (o_entry_id),
        .o_due_time      (o_due_time),
        .o_pending_count (o_pending_count)
    );

    a_req_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pending_count <= steq_pkg::CNT_W'(steq_pkg::DEPTH)))
        else $error("pending count exceeds table depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == steq_pkg::ST_FULL)
            |-> (o_pending_count == steq_pkg::CNT_W'(steq_pkg::DEPTH)))
        else $error("table full reported with free slots");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
    import steq_pkg::*;

    // op codes the block does not decode
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int         MAX_LINES   = 40;

    typedef struct packed {
        t_status              status;
        logic [ID_BITS-1:0]   entry_id;
        logic [WAKE_W-1:0]    due_time;
        logic [CNT_W-1:0]     pending;
    } queue_reply_t;

    class timer_queue_shadow;
        logic [WAKE_W-1:0]  wake_q [DEPTH];
        logic [ID_BITS-1:0] id_q [DEPTH];
        int                 count;
        logic [WAKE_W-1:0]  processed;
        logic [ID_BITS-1:0] last_id;
        bit                 popped_valid;
        logic [ID_BITS-1:0] popped_id;
        logic [WAKE_W-1:0]  popped_wake;
        queue_reply_t       awaited_results [$];
        int                 fail_count;

        function new();
            count        = 0;
            processed    = '0;
            last_id      = '0;
            popped_valid = 1'b0;
            popped_id    = '0;
            popped_wake  = '0;
            fail_count   = 0;
        endfunction

        function logic [WAKE_W-1:0] sat_sum(logic [WAKE_W-1:0] a, logic [WAKE_W-1:0] b);
            logic [WAKE_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[WAKE_W] ? '1 : s[WAKE_W-1:0];
        endfunction

        // goes behind every entry that is due no later
        function void insert_entry(logic [WAKE_W-1:0] wake, logic [ID_BITS-1:0] id);
            int pos;
            pos = 0;
            while (pos < count && wake_q[pos] <= wake)
                pos++;
            for (int k = count; k > pos; k--) begin
                wake_q[k] = wake_q[k-1];
                id_q[k]   = id_q[k-1];
            end
            wake_q[pos] = wake;
            id_q[pos]   = id;
            count++;
        endfunction

        function void remove_entry(int pos);
            for (int k = pos; k + 1 < count; k++) begin
                wake_q[k] = wake_q[k+1];
                id_q[k]   = id_q[k+1];
            end
            count--;
        endfunction

        function void note_request(logic [2:0] op, logic [ID_BITS-1:0] rid,
                                   logic [WAKE_W-1:0] amount);
            queue_reply_t      r;
            logic [WAKE_W-1:0] wake;
            int                hit;
            r.status   = ST_OK;
            r.entry_id = '0;
            r.due_time = '0;
            case (op)
                OP_SCHEDULE: begin
                    if (count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        wake = sat_sum(processed, amount);
                        last_id++;
                        insert_entry(wake, last_id);
                        r.entry_id = last_id;
                        r.due_time = wake;
                    end
                end
                OP_CANCEL: begin
                    hit = -1;
                    for (int k = 0; k < count; k++)
                        if (hit < 0 && id_q[k] == rid)
                            hit = k;
                    if (hit < 0) begin
                        r.status = ST_ABSENT;
                    end else begin
                        r.entry_id = id_q[hit];
                        r.due_time = wake_q[hit];
                        remove_entry(hit);
                    end
                end
                OP_POP_DUE: begin
                    if (count > 0 && wake_q[0] <= amount) begin
                        r.entry_id   = id_q[0];
                        r.due_time   = wake_q[0];
                        processed    = wake_q[0];
                        popped_valid = 1'b1;
                        popped_id    = id_q[0];
                        popped_wake  = wake_q[0];
                        remove_entry(0);
                    end else begin
                        r.status = ST_ABSENT;
                    end
                end
                OP_RESCHEDULE: begin
                    if (!popped_valid) begin
                        r.status = ST_NOPOP;
                    end else if (count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        wake = sat_sum(popped_wake, amount);
                        insert_entry(wake, popped_id);
                        popped_valid = 1'b0;
                        r.entry_id   = popped_id;
                        r.due_time   = wake;
                    end
                end
                OP_FINISH: begin
                    for (int k = 0; k < count; k++)
                        wake_q[k] = (wake_q[k] > amount) ? wake_q[k] - amount : '0;
                    processed    = '0;
                    popped_valid = 1'b0;
                end
                default: ;
            endcase
            r.pending = CNT_W'(count);
            awaited_results.push_back(r);
        endfunction

        function void report(string msg);
            fail_count++;
            if (fail_count <= MAX_LINES)
                $display("%0t MISMATCH: %s", $time, msg);
        endfunction

        function void check_result(logic [1:0] status, logic [ID_BITS-1:0] id,
                                   logic [WAKE_W-1:0] due, logic [CNT_W-1:0] cnt);
            queue_reply_t e;
            if (awaited_results.size() == 0) begin
                report($sformatf("result with none pending: status=%0d id=%0d due=%0d",
                                 status, id, due));
                return;
            end
            e = awaited_results.pop_front();
            if (status !== e.status)
                report($sformatf("status %0d, want %0d", status, e.status));
            if (id !== e.entry_id)
                report($sformatf("entry_id %0d, want %0d", id, e.entry_id));
            if (due !== e.due_time)
                report($sformatf("due_time %0d, want %0d", due, e.due_time));
            if (cnt !== e.pending)
                report($sformatf("pending_count %0d, want %0d", cnt, e.pending));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [2:0]           i_op;
    logic [ID_BITS-1:0]   i_routine_id;
    logic [WAKE_W-1:0]    i_amount;
    logic                 o_valid;
    logic [1:0]           o_status;
    logic [ID_BITS-1:0]   o_entry_id;
    logic [WAKE_W-1:0]    o_due_time;
    logic [CNT_W-1:0]     o_pending_count;

    timer_queue_shadow shadow = new();
    bit                gaps_on;

    sorted_timer_event_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_routine_id    (i_routine_id),
        .i_amount        (i_amount),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_entry_id      (o_entry_id),
        .o_due_time      (o_due_time),
        .o_pending_count (o_pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #250_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            shadow.check_result(o_status, o_entry_id, o_due_time, o_pending_count);
    end

    // request is taken on the first edge with busy low
    task automatic issue_request(logic [2:0] op, logic [ID_BITS-1:0] rid,
                                 logic [WAKE_W-1:0] amount);
        start        <= 1'b1;
        i_op         <= op;
        i_routine_id <= rid;
        i_amount     <= amount;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        shadow.note_request(op, rid, amount);
    endtask

    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    function automatic logic [WAKE_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    task automatic random_request(int fill_bias);
        int                 roll;
        int                 sched_w;
        logic [WAKE_W-1:0]  head;
        logic [WAKE_W-1:0]  limit;
        logic [ID_BITS-1:0] victim;
        sched_w = 15 + 17 * fill_bias;
        roll    = $urandom_range(0, 99);
        if (roll < 2) begin
            issue_request(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), 16'($urandom),
                          $urandom);
        end else if (roll < 2 + sched_w) begin
            issue_request(OP_SCHEDULE, 16'($urandom), pick_delay());
        end else if (roll < 17 + sched_w) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                    victim = (shadow.count > 0) ?
                             shadow.id_q[$urandom_range(0, shadow.count - 1)] :
                             16'($urandom);
                7:       victim = shadow.popped_id;
                8:       victim = 16'($urandom);
                default: victim = shadow.last_id + 1'b1;
            endcase
            issue_request(OP_CANCEL, victim, $urandom);
        end else if (roll < 92) begin
            if (shadow.count == 0) begin
                limit = $urandom;
            end else begin
                head = shadow.wake_q[0];
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: limit = shadow.sat_sum(head, $urandom_range(0, 20));
                    6, 7:             limit = (head == 0) ? '0 : head - 1'b1;
                    8:                limit = $urandom;
                    default:          limit = '1;
                endcase
            end
            issue_request(OP_POP_DUE, 16'($urandom), limit);
            if ($urandom_range(0, 9) < 7) begin
                maybe_gap();
                issue_request(OP_RESCHEDULE, 16'($urandom), pick_delay());
            end
        end else if (roll < 96) begin
            case ($urandom_range(0, 9))
                0:       limit = '0;
                1:       limit = $urandom;
                2:       limit = '1;
                3:       limit = shadow.processed;
                default: limit = $urandom_range(0, 60);
            endcase
            issue_request(OP_FINISH, 16'($urandom), limit);
        end else begin
            issue_request(OP_RESCHEDULE, 16'($urandom), pick_delay());
        end
    endtask

    initial begin
        int                 fill_bias;
        int                 w;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_op         <= OP_SCHEDULE;
        i_routine_id <= '0;
        i_amount     <= '0;
        gaps_on = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty-table corners
        issue_request(OP_RESCHEDULE, '0, 32'd9);
        issue_request(OP_POP_DUE, '1, '1);
        issue_request(OP_CANCEL, '1, '0);
        // ids 1..4: zero delay, max delay, a tie at 5
        issue_request(OP_SCHEDULE, '0, '0);
        issue_request(OP_SCHEDULE, '1, '1);
        issue_request(OP_SCHEDULE, '0, 32'd5);
        issue_request(OP_SCHEDULE, '0, 32'd5);
        issue_request(OP_POP_DUE, '0, '0);
        issue_request(OP_POP_DUE, '0, 32'd4);
        issue_request(OP_POP_DUE, '0, 32'd5);
        // saturates and lands behind the other max-time entry
        issue_request(OP_RESCHEDULE, '0, '1);
        issue_request(OP_CANCEL, 16'd2, '0);
        issue_request(OP_FINISH, '0, 32'd3);
        issue_request(OP_SPARE_LO, '1, '1);
        issue_request(OP_SPARE_HI, '0, '0);
        issue_request(OP_RESCHEDULE, '0, 32'd1);
        issue_request(OP_FINISH, '1, '1);

        for (int blk = 0; blk < 23; blk++) begin
            fill_bias = $urandom_range(0, 2);
            gaps_on   = (blk < 19) && (blk % 4 != 3);
            repeat (50) begin
                random_request(fill_bias);
                maybe_gap();
            end
        end
        gaps_on = 1'b0;

        // full table on both insert paths
        while (shadow.count < DEPTH)
            issue_request(OP_SCHEDULE, '0, $urandom_range(0, 40));
        issue_request(OP_SCHEDULE, '0, 32'd1);
        issue_request(OP_POP_DUE, '0, '1);
        issue_request(OP_SCHEDULE, '0, 32'd7);
        issue_request(OP_RESCHEDULE, '0, 32'd3);
        while (shadow.count > 0)
            issue_request(OP_POP_DUE, 16'($urandom), '1);
        issue_request(OP_FINISH, '0, '0);
        start <= 1'b0;

        for (w = 0; w < 4 * DEPTH + 20 && shadow.awaited_results.size() != 0; w++)
            @(posedge i_clk);
        if (shadow.awaited_results.size() != 0)
            shadow.report($sformatf("%0d results never arrived",
                                    shadow.awaited_results.size()));
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (shadow.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
